>>> hw/rtl/chacha_pkg.sv
package chacha_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_KEY_A      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_B      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_C      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_D      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NONCE_LOW  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_NONCE_HIGH = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_INIT_CTR   = 3'd6;

  // "expand 32-byte k"
  localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646e;
  localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b20_6574;

  // 10 double rounds x 2 half rounds x 4 quarter-round lines
  localparam int ROUND_STEPS = 80;
  localparam int STEP_W      = $clog2(ROUND_STEPS);

  typedef logic [15:0][WORD_W-1:0] words_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_message;
  } item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] key_word_a;
    logic [CFG_DATA_W-1:0] key_word_b;
    logic [CFG_DATA_W-1:0] key_word_c;
    logic [CFG_DATA_W-1:0] key_word_d;
    logic [CFG_DATA_W-1:0] nonce_low;
    logic [WORD_W-1:0]     nonce_high;
    logic [WORD_W-1:0]     initial_counter;
  } cfg_regs_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] counter;
  } restart_t;

  function automatic words_t make_init(cfg_regs_t c, logic [WORD_W-1:0] ctr);
    words_t w;
    w[0]  = SIGMA0;
    w[1]  = SIGMA1;
    w[2]  = SIGMA2;
    w[3]  = SIGMA3;
    w[4]  = c.key_word_a[31:0];
    w[5]  = c.key_word_a[63:32];
    w[6]  = c.key_word_b[31:0];
    w[7]  = c.key_word_b[63:32];
    w[8]  = c.key_word_c[31:0];
    w[9]  = c.key_word_c[63:32];
    w[10] = c.key_word_d[31:0];
    w[11] = c.key_word_d[63:32];
    w[12] = ctr;
    w[13] = c.nonce_low[31:0];
    w[14] = c.nonce_low[63:32];
    w[15] = c.nonce_high;
    return w;
  endfunction

  // rotate for the given quarter-round line: 16, 12, 8, 7
  function automatic logic [WORD_W-1:0] rotl_line(logic [WORD_W-1:0] v, logic [1:0] line);
    logic [WORD_W-1:0] r;
    unique case (line)
      2'd0: r = {v[15:0], v[31:16]};
      2'd1: r = {v[19:0], v[31:20]};
      2'd2: r = {v[23:0], v[31:24]};
      2'd3: r = {v[24:0], v[31:25]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/chacha_in_if.sv
interface chacha_in_if;
  logic                            valid;
  logic                            ready;
  logic [chacha_pkg::BYTE_W-1:0]   data_byte;
  logic                            last_of_message;

  modport source (output valid, output data_byte, output last_of_message, input ready);
  modport sink   (input valid, input data_byte, input last_of_message, output ready);
endinterface

>>> hw/rtl/chacha_out_if.sv
interface chacha_out_if;
  logic                            valid;
  logic                            ready;
  logic [chacha_pkg::BYTE_W-1:0]   cipher_byte;
  logic                            end_of_message;

  modport source (output valid, output cipher_byte, output end_of_message, input ready);
  modport sink   (input valid, input cipher_byte, input end_of_message, output ready);
endinterface

>>> hw/rtl/chacha_cfg_if.sv
interface chacha_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [chacha_pkg::REG_IDX_W-1:0]     reg_index;
  logic [chacha_pkg::CFG_DATA_W-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> hw/rtl/chacha_front.sv
// Request queue: accepts input bytes, holds them for the keystream core.
module chacha_front #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  chacha_in_if.sink          in_bus,
  output logic               head_valid,
  output chacha_pkg::item_t  head,
  input  logic               pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  chacha_pkg::item_t  entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push, pop_ok;
  chacha_pkg::item_t  in_item;

  assign in_bus.ready = (count_r != CNT_W'(DEPTH));
  assign push         = in_bus.valid & in_bus.ready;
  assign head_valid   = (count_r != '0);
  assign pop_ok       = pop & head_valid;
  assign head         = entries_r[rd_ptr_r];

  assign in_item.data_byte       = in_bus.data_byte;
  assign in_item.last_of_message = in_bus.last_of_message;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop_ok})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

>>> hw/rtl/chacha_back.sv
// Keystream core: block generation (one quarter-round line per cycle,
// four quarter rounds side by side), byte XOR and output register.
module chacha_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  chacha_pkg::cfg_regs_t  cfg,
  input  chacha_pkg::restart_t   restart,
  input  logic                   head_valid,
  input  chacha_pkg::item_t      head,
  output logic                   pop,
  chacha_out_if.source           out_bus
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  localparam logic [chacha_pkg::STEP_W-1:0] LAST_STEP =
    chacha_pkg::STEP_W'(chacha_pkg::ROUND_STEPS - 1);

  logic [1:0]                        state_r, state_nxt;
  logic [chacha_pkg::STEP_W-1:0]     step_r, step_nxt;
  chacha_pkg::words_t                work_r, work_nxt;
  chacha_pkg::words_t                init_w;
  logic [chacha_pkg::WORD_W-1:0]     counter_r, counter_nxt;
  logic [5:0]                        pos_r, pos_nxt;
  logic                              ready_r, ready_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [chacha_pkg::BYTE_W-1:0]     out_byte_r, out_byte_nxt;
  logic                              out_last_r, out_last_nxt;
  logic [chacha_pkg::WORD_W-1:0]     ks_word;
  logic [chacha_pkg::BYTE_W-1:0]     ks_byte;
  logic                              slot_free;
  logic                              diag;
  logic [1:0]                        line;

  assign init_w    = chacha_pkg::make_init(cfg, counter_r);
  assign ks_word   = work_r[pos_r[5:2]];
  assign ks_byte   = ks_word[{pos_r[1:0], 3'b000} +: 8];
  assign slot_free = ~out_valid_r | out_bus.ready;
  assign diag      = step_r[2];
  assign line      = step_r[1:0];

  assign out_bus.valid          = out_valid_r;
  assign out_bus.cipher_byte    = out_byte_r;
  assign out_bus.end_of_message = out_last_r;

  always_comb begin
    logic [1:0]                    qb;
    logic [3:0]                    ia, ib, ic, id, ix, iy, iz;
    logic [chacha_pkg::WORD_W-1:0] sum;

    qb            = '0;
    ia            = '0;
    ib            = '0;
    ic            = '0;
    id            = '0;
    ix            = '0;
    iy            = '0;
    iz            = '0;
    sum           = '0;
    state_nxt     = state_r;
    step_nxt      = step_r;
    work_nxt      = work_r;
    counter_nxt   = counter_r;
    pos_nxt       = pos_r;
    ready_nxt     = ready_r;
    out_valid_nxt = out_valid_r & ~out_bus.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;

    unique case (state_r)
      ST_RUN: begin
        if (head_valid) begin
          if (!ready_r) begin
            work_nxt  = init_w;
            step_nxt  = '0;
            state_nxt = ST_ROUND;
          end else if (slot_free) begin
            pop           = 1'b1;
            out_valid_nxt = 1'b1;
            out_byte_nxt  = head.data_byte ^ ks_byte;
            out_last_nxt  = head.last_of_message;
            pos_nxt       = pos_r + 1'b1;
            if (pos_r == 6'd63) begin
              counter_nxt = counter_r + 1'b1;
              ready_nxt   = 1'b0;
            end
            if (head.last_of_message) begin
              counter_nxt = cfg.initial_counter;
              pos_nxt     = '0;
              ready_nxt   = 1'b0;
            end
          end
        end
      end
      ST_ROUND: begin
        // columns when diag is low, diagonals when high
        for (int q = 0; q < 4; q++) begin
          qb = 2'(q);
          ia = {2'b00, qb};
          ib = {2'b01, qb + {1'b0, diag}};
          ic = {2'b10, qb + {diag, 1'b0}};
          id = {2'b11, qb + {diag, diag}};
          if (!line[0]) begin
            ix = ia; iy = ib; iz = id;
          end else begin
            ix = ic; iy = id; iz = ib;
          end
          sum          = work_r[ix] + work_r[iy];
          work_nxt[ix] = sum;
          work_nxt[iz] = chacha_pkg::rotl_line(work_r[iz] ^ sum, line);
        end
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < 16; i++) begin
          work_nxt[i] = work_r[i] + init_w[i];
        end
        ready_nxt = 1'b1;
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase

    // register write: restart the stream
    if (restart.valid) begin
      counter_nxt = restart.counter;
      pos_nxt     = '0;
      ready_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      step_r      <= '0;
      counter_r   <= '0;
      pos_r       <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      counter_r   <= counter_nxt;
      pos_r       <= pos_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

>>> hw/rtl/chacha20_stream_cipher_unit.sv
// ChaCha20 byte-stream cipher (256-bit key, 96-bit nonce, 32-bit block
// counter). Each request on in_bus carries one byte and a last-of-message
// flag; exactly one result comes back on out_bus, in order, holding the byte
// XOR the next keystream byte and a copy of the flag. Key, nonce and starting
// counter are written through cfg_bus (index 0..3 key words a..d, 4 nonce low,
// 5 nonce high, 6 initial counter; other indexes ignored); any valid write to
// indexes 0..6 restarts the stream at the initial counter and byte 0, and must
// only be issued while no request is outstanding. A keystream block is built
// on demand when the first byte of a block reaches the core: the state is
// loaded, the quarter-round lines run (the four quarter rounds of a half
// round run side by side, one add-xor-rotate line per cycle), and the input
// state is added back. After that the bytes of the 64-byte block are XORed
// one at a time as the output register has room. A small request queue
// (QUEUE_DEPTH entries) and a one-entry output register let both sides stall
// independently.
module chacha20_stream_cipher_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  chacha_in_if.sink     in_bus,
  chacha_out_if.source  out_bus,
  chacha_cfg_if.sink    cfg_bus
);

  chacha_pkg::cfg_regs_t  cfg_r, cfg_nxt;
  chacha_pkg::restart_t   restart;
  chacha_pkg::item_t      head;
  logic                   head_valid;
  logic                   pop;
  logic                   cfg_we;
  logic                   idx_known;

  // register file always takes writes
  assign cfg_bus.ready = 1'b1;
  assign cfg_we        = cfg_bus.valid & cfg_bus.ready;

  always_comb begin
    cfg_nxt   = cfg_r;
    idx_known = 1'b1;
    unique case (cfg_bus.reg_index)
      chacha_pkg::REG_KEY_A:      cfg_nxt.key_word_a      = cfg_bus.wdata;
      chacha_pkg::REG_KEY_B:      cfg_nxt.key_word_b      = cfg_bus.wdata;
      chacha_pkg::REG_KEY_C:      cfg_nxt.key_word_c      = cfg_bus.wdata;
      chacha_pkg::REG_KEY_D:      cfg_nxt.key_word_d      = cfg_bus.wdata;
      chacha_pkg::REG_NONCE_LOW:  cfg_nxt.nonce_low       = cfg_bus.wdata;
      chacha_pkg::REG_NONCE_HIGH: cfg_nxt.nonce_high      = cfg_bus.wdata[31:0];
      chacha_pkg::REG_INIT_CTR:   cfg_nxt.initial_counter = cfg_bus.wdata[31:0];
      default:                    idx_known               = 1'b0;
    endcase
  end

  // restart uses the counter value that is in force after this write
  assign restart.valid   = cfg_we & idx_known;
  assign restart.counter = cfg_nxt.initial_counter;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we && idx_known) begin
      cfg_r <= cfg_nxt;
    end
  end

  chacha_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  chacha_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .restart    (restart),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule
